FILE: hdl/mhap_pkg.sv
// ----------------------------------------------------------------------------
// mhap_pkg
// Shared types and constants for the acceptance probability pipeline.
// ----------------------------------------------------------------------------
package mhap_pkg;

  // probability of one in Q1.16
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // number of Taylor terms used for exp(-r)
  localparam int TAYLOR_TERMS = 16;

  // reset values of the configuration registers
  localparam logic [23:0]        INV_TEMP_RST   = 24'd65536;
  localparam logic signed [31:0] LOW_BOUND_RST  = -32'sd65536;
  localparam logic signed [31:0] HIGH_BOUND_RST = 32'sd65536;
  localparam logic [30:0]        HALF_WIDTH_RST = 31'd6554;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_INV_TEMP   = 2'd0,
    REG_LOW_BOUND  = 2'd1,
    REG_HIGH_BOUND = 2'd2,
    REG_HALF_WIDTH = 2'd3
  } cfg_reg_t;

  // configuration as seen by the datapath
  typedef struct packed {
    logic [23:0]        inv_temp;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic [30:0]        half_width;
  } cfg_t;

  // beat leaving the window stage
  typedef struct packed {
    logic               vld;
    logic               err;
    logic [31:0]        wc;
    logic [31:0]        wn;
    logic signed [32:0] diff;
  } win_beat_t;

  // beat leaving the exponential unit
  typedef struct packed {
    logic        vld;
    logic        err;
    logic [31:0] wc;
    logic [31:0] wn;
    logic [7:0]  nq;
    logic [32:0] e;
  } exp_beat_t;

endpackage

FILE: hdl/mhap_window.sv
// ----------------------------------------------------------------------------
// mhap_window
// Clipped proposal window lengths for both values, range check, energy delta.
// ----------------------------------------------------------------------------
module mhap_window (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  mhap_pkg::cfg_t      cfg,
  input  logic                in_vld,
  input  logic signed [31:0]  value_cur,
  input  logic signed [31:0]  value_next,
  input  logic signed [31:0]  energy_cur,
  input  logic signed [31:0]  energy_next,
  output mhap_pkg::win_beat_t beat_o
);

  mhap_pkg::win_beat_t beat_r;
  mhap_pkg::win_beat_t beat_nxt;

  // window length; bit 32 set when the length is usable (inside and nonzero)
  function automatic logic [32:0] win_len(input logic signed [31:0] y,
                                          input mhap_pkg::cfg_t c);
    logic signed [34:0] ys, as, bs, hs, ah, bh, w;
    ys = 35'(y);
    as = 35'(c.low_bound);
    bs = 35'(c.high_bound);
    hs = $signed({4'b0, c.half_width});
    ah = as + hs;
    bh = bs - hs;
    if (as < ys && ys < ah) begin
      w = ys - as + hs;
    end else if (ah <= ys && ys < bh) begin
      w = hs + hs;
    end else if (bh <= ys && ys < bs) begin
      w = bs - ys + hs;
    end else begin
      w = '0;
    end
    return {(w != '0), w[31:0]};
  endfunction

  always_comb begin
    logic [32:0] lc, ln;
    lc = win_len(value_cur, cfg);
    ln = win_len(value_next, cfg);
    beat_nxt.vld  = in_vld;
    beat_nxt.err  = !(lc[32] && ln[32]);
    beat_nxt.wc   = lc[31:0];
    beat_nxt.wn   = ln[31:0];
    beat_nxt.diff = $signed({energy_next[31], energy_next})
                  - $signed({energy_cur[31], energy_cur});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_o = beat_r;

endmodule

FILE: hdl/mhap_expo.sv
// ----------------------------------------------------------------------------
// mhap_expo
// z = beta*dE, range reduction by ln2, exp(-r) by a pipelined Taylor series.
// ----------------------------------------------------------------------------
module mhap_expo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [23:0]         inv_temp,
  input  mhap_pkg::win_beat_t beat_i,
  output mhap_pkg::exp_beat_t beat_o
);

  localparam logic [31:0]        LN2_Q32  = 32'd2977044472;
  localparam logic signed [57:0] Z_CLAMP  = 58'sd206158430208;  // 48 in Q.32
  localparam logic signed [57:0] Z_OFFSET = 58'sd208393113040;  // 70 * ln2
  localparam int                 NT       = mhap_pkg::TAYLOR_TERMS;

  typedef struct packed {
    logic               vld;
    logic               err;
    logic [31:0]        wc;
    logic [31:0]        wn;
    logic signed [57:0] z;
  } mul_t;

  typedef struct packed {
    logic        vld;
    logic        err;
    logic [31:0] wc;
    logic [31:0] wn;
    logic [38:0] rem;
    logic [7:0]  nq;
  } div_t;

  typedef struct packed {
    logic               vld;
    logic               err;
    logic [31:0]        wc;
    logic [31:0]        wn;
    logic [7:0]         nq;
    logic [31:0]        r;
    logic [31:0]        term;
    logic [31:0]        p;
    logic signed [33:0] sum;
  } tay_t;

  // floor(p / d) for 2 <= d <= 16 by exact reciprocal multiply
  function automatic logic [31:0] div_const(input logic [31:0] p, input logic [4:0] d);
    logic [32:0] m;
    logic [5:0]  sh;
    logic [64:0] prod;
    case (d)
      5'd2:    begin m = 33'd4294967296; sh = 6'd33; end
      5'd3:    begin m = 33'd5726623062; sh = 6'd34; end
      5'd4:    begin m = 33'd4294967296; sh = 6'd34; end
      5'd5:    begin m = 33'd6871947674; sh = 6'd35; end
      5'd6:    begin m = 33'd5726623062; sh = 6'd35; end
      5'd7:    begin m = 33'd4908534053; sh = 6'd35; end
      5'd8:    begin m = 33'd4294967296; sh = 6'd35; end
      5'd9:    begin m = 33'd7635497416; sh = 6'd36; end
      5'd10:   begin m = 33'd6871947674; sh = 6'd36; end
      5'd11:   begin m = 33'd6247225158; sh = 6'd36; end
      5'd12:   begin m = 33'd5726623062; sh = 6'd36; end
      5'd13:   begin m = 33'd5286113596; sh = 6'd36; end
      5'd14:   begin m = 33'd4908534053; sh = 6'd36; end
      5'd15:   begin m = 33'd4581298450; sh = 6'd36; end
      5'd16:   begin m = 33'd4294967296; sh = 6'd36; end
      default: begin m = 33'd4294967296; sh = 6'd32; end
    endcase
    prod = {33'b0, p} * {32'b0, m};
    return 32'(prod >> sh);
  endfunction

  mul_t m_r;
  div_t c_r;
  div_t d_r  [0:3];
  div_t dsrc [0:3];
  tay_t a_r  [2:NT];
  tay_t b_r  [2:NT];
  tay_t tsrc [2:NT];
  tay_t f_r;

  // stage: beta * delta energy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r.vld <= 1'b0;
    end else if (en) begin
      m_r.vld <= beat_i.vld;
      m_r.err <= beat_i.err;
      m_r.wc  <= beat_i.wc;
      m_r.wn  <= beat_i.wn;
      m_r.z   <= $signed({1'b0, inv_temp}) * beat_i.diff;
    end
  end

  // stage: clamp and offset so that the quotient is never negative
  always_ff @(posedge clk) begin
    logic signed [57:0] zc, zs;
    if (m_r.z > Z_CLAMP) begin
      zc = Z_CLAMP;
    end else if (m_r.z < -Z_CLAMP) begin
      zc = -Z_CLAMP;
    end else begin
      zc = m_r.z;
    end
    zs = zc + Z_OFFSET;
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else if (en) begin
      c_r.vld <= m_r.vld;
      c_r.err <= m_r.err;
      c_r.wc  <= m_r.wc;
      c_r.wn  <= m_r.wn;
      c_r.rem <= zs[38:0];
      c_r.nq  <= '0;
    end
  end

  // restoring division by ln2, two quotient bits per stage
  genvar s;
  generate
    for (s = 0; s < 4; s++) begin : g_div
      if (s == 0) begin : g_first
        assign dsrc[s] = c_r;
      end else begin : g_next
        assign dsrc[s] = d_r[s-1];
      end

      always_ff @(posedge clk) begin
        div_t        nx;
        logic [38:0] sub;
        logic [2:0]  bp;
        nx = dsrc[s];
        for (int i = 0; i < 2; i++) begin
          bp  = 3'(7 - 2 * s - i);
          sub = 39'(LN2_Q32) << bp;
          if (nx.rem >= sub) begin
            nx.rem    = nx.rem - sub;
            nx.nq[bp] = 1'b1;
          end
        end
        if (!rst_n) begin
          d_r[s].vld <= 1'b0;
        end else if (en) begin
          d_r[s] <= nx;
        end
      end
    end
  endgenerate

  // seed of the series: term 1 is r, sum before it is one
  always_comb begin
    tsrc[2].vld  = d_r[3].vld;
    tsrc[2].err  = d_r[3].err;
    tsrc[2].wc   = d_r[3].wc;
    tsrc[2].wn   = d_r[3].wn;
    tsrc[2].nq   = d_r[3].nq;
    tsrc[2].r    = d_r[3].rem[31:0];
    tsrc[2].term = d_r[3].rem[31:0];
    tsrc[2].p    = '0;
    tsrc[2].sum  = 34'sd4294967296;
  end

  // Taylor terms: multiply by r, then divide by k; sum lags one term
  genvar k;
  generate
    for (k = 2; k <= NT; k++) begin : g_tay
      localparam bit PREV_ODD = ((k - 1) % 2) == 1;

      if (k > 2) begin : g_link
        assign tsrc[k] = b_r[k-1];
      end

      always_ff @(posedge clk) begin
        tay_t        nx;
        logic [63:0] prod;
        nx   = tsrc[k];
        prod = {32'b0, nx.term} * {32'b0, nx.r};
        nx.p = prod[63:32];
        if (PREV_ODD) begin
          nx.sum = nx.sum - $signed({2'b0, nx.term});
        end else begin
          nx.sum = nx.sum + $signed({2'b0, nx.term});
        end
        if (!rst_n) begin
          a_r[k].vld <= 1'b0;
        end else if (en) begin
          a_r[k] <= nx;
        end
      end

      always_ff @(posedge clk) begin
        tay_t nx;
        nx      = a_r[k];
        nx.term = div_const(a_r[k].p, 5'(k));
        if (!rst_n) begin
          b_r[k].vld <= 1'b0;
        end else if (en) begin
          b_r[k] <= nx;
        end
      end
    end
  endgenerate

  // add the last term (even index, positive)
  always_ff @(posedge clk) begin
    tay_t nx;
    nx     = b_r[NT];
    nx.sum = nx.sum + $signed({2'b0, nx.term});
    if (!rst_n) begin
      f_r.vld <= 1'b0;
    end else if (en) begin
      f_r <= nx;
    end
  end

  assign beat_o.vld = f_r.vld;
  assign beat_o.err = f_r.err;
  assign beat_o.wc  = f_r.wc;
  assign beat_o.wn  = f_r.wn;
  assign beat_o.nq  = f_r.nq;
  assign beat_o.e   = f_r.sum[32:0];

endmodule

FILE: hdl/mhap_qdiv.sv
// ----------------------------------------------------------------------------
// mhap_qdiv
// Weight by window ratio, scale by 2^k and saturating quotient, bit per stage.
// ----------------------------------------------------------------------------
module mhap_qdiv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  mhap_pkg::exp_beat_t beat_i,
  output logic                out_vld,
  output logic [16:0]         out_prob,
  output logic                out_err
);

  localparam int QW = 106;

  typedef struct packed {
    logic              vld;
    logic              err;
    logic [56:0]       num;
    logic signed [8:0] kk;
    logic [31:0]       wn;
  } num_t;

  typedef struct packed {
    logic          vld;
    logic          err;
    logic          sat;
    logic          zero;
    logic [QW-1:0] rem;
    logic [QW-1:0] dv;
    logic [15:0]   acc;
  } qd_t;

  num_t        n_r;
  qd_t         s_r;
  qd_t         qd_r [0:16];
  logic        out_vld_r;
  logic [16:0] out_prob_r;
  logic        out_err_r;

  // stage: numerator and binary exponent k = 62 - nq
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r.vld <= 1'b0;
    end else if (en) begin
      n_r.vld <= beat_i.vld;
      n_r.err <= beat_i.err;
      n_r.num <= {32'b0, beat_i.e[32:8]} * {25'b0, beat_i.wc};
      n_r.kk  <= 9'sd62 - $signed({1'b0, beat_i.nq});
      n_r.wn  <= beat_i.wn;
    end
  end

  // stage: apply 2^k on the side it belongs to
  always_ff @(posedge clk) begin
    qd_t               nx;
    logic signed [8:0] nk;
    logic [4:0]        kp;
    logic [5:0]        sd;
    nk      = -n_r.kk;
    nx.vld  = n_r.vld;
    nx.err  = n_r.err;
    nx.sat  = n_r.kk > 9'sd24;
    nx.zero = n_r.kk < -9'sd56;
    kp      = (n_r.kk > 9'sd0 && !nx.sat) ? n_r.kk[4:0] : 5'd0;
    sd      = (n_r.kk < 9'sd0 && !nx.zero) ? nk[5:0] : 6'd0;
    nx.rem  = QW'(n_r.num) << kp;
    nx.dv   = QW'(n_r.wn) << sd;
    nx.acc  = '0;
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else if (en) begin
      s_r <= nx;
    end
  end

  // stage: quotient of 65536 or more saturates
  always_ff @(posedge clk) begin
    qd_t nx;
    nx = s_r;
    if (!nx.zero && nx.rem >= (nx.dv << 16)) begin
      nx.sat = 1'b1;
    end
    if (!rst_n) begin
      qd_r[0].vld <= 1'b0;
    end else if (en) begin
      qd_r[0] <= nx;
    end
  end

  // restoring division, one quotient bit per stage from bit 15 down
  genvar t;
  generate
    for (t = 1; t <= 16; t++) begin : g_bit
      localparam int J = 16 - t;
      always_ff @(posedge clk) begin
        qd_t           nx;
        logic [QW-1:0] sub;
        nx  = qd_r[t-1];
        sub = nx.dv << J;
        if (nx.rem >= sub) begin
          nx.rem    = nx.rem - sub;
          nx.acc[J] = 1'b1;
        end
        if (!rst_n) begin
          qd_r[t].vld <= 1'b0;
        end else if (en) begin
          qd_r[t] <= nx;
        end
      end
    end
  endgenerate

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= qd_r[16].vld;
      out_err_r <= qd_r[16].err;
      if (qd_r[16].err || qd_r[16].zero) begin
        out_prob_r <= '0;
      end else if (qd_r[16].sat) begin
        out_prob_r <= mhap_pkg::ONE_Q16;
      end else begin
        out_prob_r <= {1'b0, qd_r[16].acc};
      end
    end
  end

  assign out_vld  = out_vld_r;
  assign out_prob = out_prob_r;
  assign out_err  = out_err_r;

endmodule

FILE: hdl/metropolis_hastings_accept_prob_top.sv
// ----------------------------------------------------------------------------
// metropolis_hastings_accept_prob_top: Metropolis-Hastings acceptance probability
// Throughput: one beat per cycle; every stage advances together on no stall.
// Reset: synchronous; clears stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module metropolis_hastings_accept_prob_top (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_value_cur,
  input  logic signed [31:0] in_value_next,
  input  logic signed [31:0] in_energy_cur,
  input  logic signed [31:0] in_energy_next,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [16:0]        out_accept_prob,
  output logic               out_range_error,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  mhap_pkg::cfg_t      cfg_r;
  mhap_pkg::win_beat_t win_beat;
  mhap_pkg::exp_beat_t exp_beat;
  logic                en;

  // pipeline moves whenever the output slot is free or being taken
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_temp   <= mhap_pkg::INV_TEMP_RST;
      cfg_r.low_bound  <= mhap_pkg::LOW_BOUND_RST;
      cfg_r.high_bound <= mhap_pkg::HIGH_BOUND_RST;
      cfg_r.half_width <= mhap_pkg::HALF_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mhap_pkg::cfg_reg_t'(cfg_index))
        mhap_pkg::REG_INV_TEMP:   cfg_r.inv_temp   <= cfg_data[23:0];
        mhap_pkg::REG_LOW_BOUND:  cfg_r.low_bound  <= $signed(cfg_data);
        mhap_pkg::REG_HIGH_BOUND: cfg_r.high_bound <= $signed(cfg_data);
        mhap_pkg::REG_HALF_WIDTH: cfg_r.half_width <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  mhap_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .cfg         (cfg_r),
    .in_vld      (in_valid),
    .value_cur   (in_value_cur),
    .value_next  (in_value_next),
    .energy_cur  (in_energy_cur),
    .energy_next (in_energy_next),
    .beat_o      (win_beat)
  );

  mhap_expo u_expo (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .inv_temp (cfg_r.inv_temp),
    .beat_i   (win_beat),
    .beat_o   (exp_beat)
  );

  mhap_qdiv u_qdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .beat_i   (exp_beat),
    .out_vld  (out_valid),
    .out_prob (out_accept_prob),
    .out_err  (out_range_error)
  );

  // a range error never carries a nonzero probability
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |-> (out_accept_prob == 17'd0))
    else $error("range error beat with nonzero probability");

  // probability never exceeds one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accept_prob <= mhap_pkg::ONE_Q16))
    else $error("probability above one");

  // a held result must block the input side
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result is held");

endmodule

FILE: verif/mhap_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mhap_checker
// Watches the input, result and register channels of the acceptance
// probability block, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module mhap_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_value_cur,
  input  logic signed [31:0] in_value_next,
  input  logic signed [31:0] in_energy_cur,
  input  logic signed [31:0] in_energy_next,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [16:0]        out_accept_prob,
  input  logic               out_range_error,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam longint LN2_Q32 = 64'sd2977044472;
  localparam longint Z_LIMIT = 64'sd48 * 64'sd4294967296;

  typedef struct packed {
    logic [16:0] prob;
    logic        err;
  } prob_beat_t;

  // shadow copy of the registers
  longint beta_q;
  longint lo_b;
  longint hi_b;
  longint half_w;

  prob_beat_t expected_probs[$];

  // clipped proposal window length, 0 when the value is not allowed
  function automatic longint window_len(longint y);
    if (lo_b < y && y < lo_b + half_w) return y - lo_b + half_w;
    if (lo_b + half_w <= y && y < hi_b - half_w) return 2 * half_w;
    if (hi_b - half_w <= y && y < hi_b) return hi_b - y + half_w;
    return 0;
  endfunction

  // exp(-r) in Q.32 by a Taylor series, 0 <= r < ln2
  function automatic longint unsigned exp_frac(longint unsigned r);
    longint          acc;
    longint unsigned term;
    acc  = 64'sd4294967296;
    term = 64'd4294967296;
    for (int k = 1; k <= mhap_pkg::TAYLOR_TERMS; k++) begin
      term = ((term * r) >> 32) / k;
      if (k % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    return longint'(acc);
  endfunction

  function automatic prob_beat_t accept_prob_of(logic signed [31:0] yc, logic signed [31:0] yn,
                                               logic signed [31:0] ec, logic signed [31:0] en);
    prob_beat_t      res;
    longint          wc, wn, z, n, r, k;
    longint unsigned e, num, q;
    wc = window_len(longint'(yc));
    wn = window_len(longint'(yn));
    res = '0;
    if (wc <= 0 || wn <= 0) begin
      res.err = 1'b1;
      return res;
    end
    z = beta_q * (longint'(en) - longint'(ec));
    if (z > Z_LIMIT) z = Z_LIMIT;
    if (z < -Z_LIMIT) z = -Z_LIMIT;
    n = z / LN2_Q32;
    if (z % LN2_Q32 != 0 && z < 0) n = n - 1;
    r = z - n * LN2_Q32;
    e = exp_frac(longint'(r));
    num = (e >> 8) * longint'(wc);
    k = -n - 8;
    if (k >= 0) begin
      while (k > 0 && num < (64'd1 << 62)) begin
        num = num << 1;
        k = k - 1;
      end
      if (k > 0) q = 64'd65536;
      else       q = num / longint'(wn);
    end else if (-k >= 64) begin
      q = 0;
    end else begin
      q = (num >> (-k)) / longint'(wn);
    end
    if (q > 64'd65536) q = 64'd65536;
    res.prob = q[16:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = expected_probs.size();

  initial fail_count = 0;

  // register writes and input beats
  always @(posedge clk) begin
    if (!rst_n) begin
      beta_q = longint'(mhap_pkg::INV_TEMP_RST);
      lo_b   = longint'(mhap_pkg::LOW_BOUND_RST);
      hi_b   = longint'(mhap_pkg::HIGH_BOUND_RST);
      half_w = longint'(mhap_pkg::HALF_WIDTH_RST);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (mhap_pkg::cfg_reg_t'(cfg_index))
          mhap_pkg::REG_INV_TEMP:   beta_q = longint'(cfg_data[23:0]);
          mhap_pkg::REG_LOW_BOUND:  lo_b   = longint'(signed'(cfg_data));
          mhap_pkg::REG_HIGH_BOUND: hi_b   = longint'(signed'(cfg_data));
          mhap_pkg::REG_HALF_WIDTH: half_w = longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_probs.push_back(accept_prob_of(in_value_cur, in_value_next,
                                                in_energy_cur, in_energy_next));
    end
  end

  // result beats
  always @(posedge clk) begin
    prob_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_probs.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = expected_probs.pop_front();
        if (out_accept_prob !== want.prob)
          report_mismatch("accept_prob", out_accept_prob, want.prob);
        if (out_range_error !== want.err)
          report_mismatch("range_error", out_range_error, want.err);
      end
    end
  end

endmodule

FILE: verif/metropolis_hastings_accept_prob_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// metropolis_hastings_accept_prob_top_tb
// Drives directed and random site updates through the acceptance probability
// block under several register settings and idle patterns; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module metropolis_hastings_accept_prob_top_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int ITEMS_PER_SET  = 65;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_value_cur;
  logic signed [31:0] in_value_next;
  logic signed [31:0] in_energy_cur;
  logic signed [31:0] in_energy_next;
  logic               out_valid;
  logic               out_stall;
  logic [16:0]        out_accept_prob;
  logic               out_range_error;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 fail_count;
  int                 pending;

  int     send_idle_pct;
  int     recv_idle_pct;
  int     quiet_cycles;
  // stimulus copy of the interval
  longint lo_b, hi_b, half_w;

  metropolis_hastings_accept_prob_top u_top (.*);

  mhap_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one register beat; the caller drops cfg_valid after the last one
  task automatic write_reg(mhap_pkg::cfg_reg_t idx, logic [31:0] data);
    logic rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // writes all registers once the pipeline has drained
  task automatic load_regs(logic [23:0] beta, logic [31:0] lo, logic [31:0] hi,
                           logic [30:0] hw);
    @(posedge clk);
    wait (pending == 0);
    repeat (70) @(posedge clk);
    write_reg(mhap_pkg::REG_INV_TEMP, {8'd0, beta});
    write_reg(mhap_pkg::REG_LOW_BOUND, lo);
    write_reg(mhap_pkg::REG_HIGH_BOUND, hi);
    write_reg(mhap_pkg::REG_HALF_WIDTH, {1'b0, hw});
    cfg_valid <= 1'b0;
    lo_b   = longint'(signed'(lo));
    hi_b   = longint'(signed'(hi));
    half_w = longint'(hw);
  endtask

  task automatic send_update(logic [31:0] yc, logic [31:0] yn, logic [31:0] ec,
                             logic [31:0] en);
    logic stl;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value_cur   <= yc;
    in_value_next  <= yn;
    in_energy_cur  <= ec;
    in_energy_next <= en;
    do begin
      @(negedge clk);
      stl = in_stall;
      @(posedge clk);
    end while (stl);
  endtask

  // site value: mostly inside the interval, some at the window corners
  function automatic logic [31:0] pick_value();
    longint span, v;
    int     sel;
    sel  = $urandom_range(99);
    span = hi_b - lo_b - 1;
    if (sel < 60 && span > 0) begin
      v = lo_b + 1 + ((longint'({$urandom, $urandom}) & 64'h7fff_ffff_ffff_ffff) % span);
    end else if (sel < 85) begin
      case ($urandom_range(7))
        0: v = lo_b;
        1: v = lo_b + 1;
        2: v = lo_b + half_w - 1;
        3: v = lo_b + half_w;
        4: v = hi_b - half_w - 1;
        5: v = hi_b - half_w;
        6: v = hi_b - 1;
        default: v = hi_b;
      endcase
    end else begin
      v = longint'($urandom);
    end
    return v[31:0];
  endfunction

  task automatic send_random_update();
    logic [31:0] ec, en;
    ec = $urandom;
    case ($urandom_range(3))
      0: en = $urandom;
      1: en = ec + $urandom_range(255) - 128;
      2: en = ec + $urandom_range(1 << 20) - (1 << 19);
      default: en = ec;
    endcase
    send_update(pick_value(), pick_value(), ec, en);
  endtask

  task automatic load_set(int sel);
    case (sel)
      0: load_regs(mhap_pkg::INV_TEMP_RST, mhap_pkg::LOW_BOUND_RST,
                   mhap_pkg::HIGH_BOUND_RST, mhap_pkg::HALF_WIDTH_RST);
      1: load_regs(24'hff_ffff, 32'h8000_0000, 32'h7fff_ffff, 31'h7fff_ffff);
      2: load_regs(24'd0, -32'sd655360, 32'sd655360, 31'd1);
      3: load_regs(24'd4096, 32'sd65536, -32'sd65536, 31'd6554);
      4: load_regs(24'd1, -32'sd32768, 32'sd98304, 31'd0);
      default: load_regs($urandom_range(24'hff_ffff), -$urandom_range(1 << 24),
                         $urandom_range(1 << 24), $urandom_range(1 << 20) + 1);
    endcase
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_value_cur   = '0;
    in_value_next  = '0;
    in_energy_cur  = '0;
    in_energy_next = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = mhap_pkg::REG_INV_TEMP;
    cfg_data       = '0;
    quiet_cycles   = 0;
    send_idle_pct  = 31;
    recv_idle_pct  = 70;
    lo_b   = longint'(mhap_pkg::LOW_BOUND_RST);
    hi_b   = longint'(mhap_pkg::HIGH_BOUND_RST);
    half_w = longint'(mhap_pkg::HALF_WIDTH_RST);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats under reset settings
    send_update(32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_update(-32'sd65535, 32'sd65535, 32'sd100, 32'sd0);
    send_update(32'sd65535, -32'sd65535, 32'sd0, 32'sd100);
    send_update(-32'sd58982, 32'sd58982, 32'sd0, 32'sd0);
    send_update(-32'sd58983, 32'sd58981, 32'sd0, 32'sd65536);
    send_update(-32'sd65536, 32'sd0, 32'sd0, 32'sd0);
    send_update(32'sd0, 32'sd65536, 32'sd0, 32'sd0);
    send_update(32'h8000_0000, 32'h7fff_ffff, 32'sd0, 32'sd0);
    send_update(32'sd0, 32'sd1000, 32'h8000_0000, 32'h7fff_ffff);
    send_update(32'sd1000, 32'sd0, 32'h7fff_ffff, 32'h8000_0000);
    send_update(32'sd0, 32'sd0, 32'sd0, 32'sd45426);
    send_update(32'sd0, 32'sd0, 32'sd45426, 32'sd0);
    send_update(32'sd0, 32'sd0, 32'sd0, 32'sd1);
    send_update(32'sd0, 32'sd0, 32'sd1, 32'sd0);
    send_update(32'hffff_ffff, 32'sd1, 32'hffff_ffff, 32'hffff_ffff);

    // random beats: three idle patterns, several register settings each
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct = 70;
        recv_idle_pct = 31;
      end else if (phase == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int j = 0; j < 4; j++) begin
        in_valid <= 1'b0;
        load_set((phase * 4 + j) % 7);
        for (int i = 0; i < ITEMS_PER_SET; i++) send_random_update();
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
